// ===== rtl/core/tcm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcm_pkg: shared constants for the triangle classifier
// Field widths, register indexes, triangle kind codes and small helpers.
// ----------------------------------------------------------------------------
package tcm_pkg;

  localparam int DEF_SIDE_INT_BITS  = 16;
  localparam int DEF_SIDE_FRAC_BITS = 8;

  localparam int IN_W       = 24;
  localparam int KIND_W     = 3;
  localparam int AREA_W     = 40;
  localparam int RAD_W      = 24;
  localparam int OUTR_W     = 32;
  localparam int QUO_W      = 32;
  localparam int SIDE_TOL_W = 8;
  localparam int SQ_TOL_W   = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_SIDE_TOL   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SQUARE_TOL = 2'd1;

  localparam logic [KIND_W-1:0] KIND_DEGEN   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SCALENE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_EQUI    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ISO     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ISO_RT  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_RIGHT   = 3'd5;

  function automatic int maxi(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== rtl/core/tcm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcm_if: channel interfaces of the triangle classifier
// Side input channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface tcm_side_if;
  import tcm_pkg::*;
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] side_one;
  logic [IN_W-1:0] side_two;
  logic [IN_W-1:0] side_three;
  modport source (output valid, side_one, side_two, side_three, input ready);
  modport sink   (input valid, side_one, side_two, side_three, output ready);
endinterface

interface tcm_result_if;
  import tcm_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [AREA_W-1:0] area;
  logic [RAD_W-1:0]  inner_radius;
  logic [OUTR_W-1:0] outer_radius;
  logic [RAD_W-1:0]  height;
  logic [RAD_W-1:0]  median;
  logic              radius_clipped;
  modport source (output valid, kind, area, inner_radius, outer_radius, height, median,
                  radius_clipped, input ready);
  modport sink   (input valid, kind, area, inner_radius, outer_radius, height, median,
                  radius_clipped, output ready);
endinterface

interface tcm_cfg_if;
  import tcm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// ===== rtl/core/triangle_classify_measure.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_classify_measure: triangle classifier with Heron area and radii
// Sorts three fixed-point sides, classifies the triangle and measures it.
// ----------------------------------------------------------------------------
// One triangle enters per clock unless the pipeline holds, and its result
// passes 5 front stages (sort, sums and squares, products, partial products,
// final products), then one stage per root bit of the Heron square root
// ((4W+2-2F)/2 stages, W = SIDE_INT_BITS + SIDE_FRAC_BITS, F = SIDE_FRAC_BITS),
// then 33 divider stages and one output register. Sides are Q16.8 by default.
// The whole pipeline advances together; it holds only while the output
// register carries an item that the sink has not taken. Results are exact
// for W up to 30. Configuration writes are taken at any time, but the side
// tolerance is read in the second stage and the square tolerance in the third,
// so an item already in the first stages sees the new value; write the
// registers only while no item is in flight. cfg.ready is always high.
// ----------------------------------------------------------------------------
module triangle_classify_measure #(
  parameter int SIDE_INT_BITS  = tcm_pkg::DEF_SIDE_INT_BITS,
  parameter int SIDE_FRAC_BITS = tcm_pkg::DEF_SIDE_FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst,
  tcm_side_if.sink     side,
  tcm_result_if.source result,
  tcm_cfg_if.sink      cfg
);
  import tcm_pkg::*;

  localparam int W      = SIDE_INT_BITS + SIDE_FRAC_BITS;
  localparam int F      = SIDE_FRAC_BITS;
  localparam int SUM_W  = W + 2;
  localparam int DIF_W  = W + 1;
  localparam int P1_W   = SUM_W + DIF_W;
  localparam int P2_W   = 2 * DIF_W;
  localparam int SQ_W   = 2 * W;
  localparam int HALF   = (P1_W + 1) / 2;
  localparam int PROD_W = P1_W + P2_W;
  localparam int ABC_W  = 3 * W;
  localparam int X_W    = PROD_W - (2 * F + 4);
  localparam int RW     = (X_W + 1) / 2;
  localparam int NR_W   = maxi(RW + F + 1, QUO_W);
  localparam int NO_W   = maxi(ABC_W, QUO_W);
  localparam int DO_W   = RW + F + 2;

  // ---------------------------------------------------------------- config
  logic [SIDE_TOL_W-1:0] side_tol;
  logic [SQ_TOL_W-1:0]   square_tol;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_tol   <= '0;
      square_tol <= '0;
    end else if (cfg.valid) begin
      case (cfg.addr)
        REG_SIDE_TOL:   side_tol   <= cfg.data[SIDE_TOL_W-1:0];
        REG_SQUARE_TOL: square_tol <= cfg.data[SQ_TOL_W-1:0];
        default: ;   // drop writes to unknown registers
      endcase
    end
  end

  // The whole pipeline moves as one; hold only when the output item waits.
  logic en;
  assign en = !result.valid || result.ready;
  assign side.ready = en;

  // ---------------------------------------------------------------- stage 1: sort
  logic [W-1:0] x0, x1, x2, t0, t1, m1, u2, v0, v1;
  always_comb begin
    x0 = W'(side.side_one);
    x1 = W'(side.side_two);
    x2 = W'(side.side_three);
    t0 = (x0 > x1) ? x1 : x0;
    t1 = (x0 > x1) ? x0 : x1;
    m1 = (t1 > x2) ? x2 : t1;
    u2 = (t1 > x2) ? t1 : x2;
    v0 = (t0 > m1) ? m1 : t0;
    v1 = (t0 > m1) ? t0 : m1;
  end

  logic         st1_vld;
  logic [W-1:0] st1_s0, st1_s1, st1_s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_vld <= 1'b0;
    end else if (en) begin
      st1_vld <= side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1_s0 <= v0;
      st1_s1 <= v1;
      st1_s2 <= u2;
    end
  end

  // ---------------------------------------------------------------- stage 2: sums, squares
  logic [W-1:0] d01, d02, d12;
  assign d01 = (st1_s1 > st1_s0) ? st1_s1 - st1_s0 : st1_s0 - st1_s1;
  assign d02 = st1_s2 - st1_s0;
  assign d12 = st1_s2 - st1_s1;

  logic             st2_vld, st2_ok, st2_eq01, st2_eq02, st2_eq12;
  logic [SUM_W-1:0] st2_sum;
  logic [DIF_W-1:0] st2_da, st2_db, st2_dc;
  logic [SQ_W-1:0]  st2_sq0, st2_sq1, st2_sq2;
  logic [W-1:0]     st2_s0, st2_s1, st2_s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      st2_vld <= 1'b0;
    end else if (en) begin
      st2_vld <= st1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st2_sum  <= SUM_W'(st1_s0) + SUM_W'(st1_s1) + SUM_W'(st1_s2);
      st2_da   <= DIF_W'(st1_s1) + DIF_W'(st1_s2) - DIF_W'(st1_s0);
      st2_db   <= DIF_W'(st1_s0) + DIF_W'(st1_s2) - DIF_W'(st1_s1);
      st2_dc   <= DIF_W'(st1_s0) + DIF_W'(st1_s1) - DIF_W'(st1_s2);
      st2_ok   <= (DIF_W'(st1_s0) + DIF_W'(st1_s1)) > DIF_W'(st1_s2);
      st2_sq0  <= SQ_W'(st1_s0) * SQ_W'(st1_s0);
      st2_sq1  <= SQ_W'(st1_s1) * SQ_W'(st1_s1);
      st2_sq2  <= SQ_W'(st1_s2) * SQ_W'(st1_s2);
      st2_eq01 <= d01 <= W'(side_tol);
      st2_eq02 <= d02 <= W'(side_tol);
      st2_eq12 <= d12 <= W'(side_tol);
      st2_s0   <= st1_s0;
      st2_s1   <= st1_s1;
      st2_s2   <= st1_s2;
    end
  end

  // ---------------------------------------------------------------- stage 3: classify, products
  logic [SQ_W:0]       sq_sum, sq_dif;
  logic                right;
  logic [KIND_W-1:0]   kind_c;
  logic [W-1:0]        base_c;

  always_comb begin
    sq_sum = (SQ_W+1)'(st2_sq0) + (SQ_W+1)'(st2_sq1);
    sq_dif = (sq_sum > (SQ_W+1)'(st2_sq2)) ? sq_sum - (SQ_W+1)'(st2_sq2)
                                           : (SQ_W+1)'(st2_sq2) - sq_sum;
    right  = sq_dif <= (SQ_W+1)'(square_tol);
    base_c = st2_s2;
    // check order: degenerate, equilateral, short pair, long pair, right, scalene
    if (!st2_ok) begin
      kind_c = KIND_DEGEN;
    end else if (st2_eq02) begin
      kind_c = KIND_EQUI;
    end else if (st2_eq01) begin
      kind_c = right ? KIND_ISO_RT : KIND_ISO;
    end else if (st2_eq12) begin
      kind_c = KIND_ISO;
      base_c = st2_s0;
    end else if (right) begin
      kind_c = KIND_RIGHT;
    end else begin
      kind_c = KIND_SCALENE;
    end
  end

  logic              st3_vld;
  logic [P1_W-1:0]   st3_p1;
  logic [P2_W-1:0]   st3_p2;
  logic [SQ_W-1:0]   st3_ab;
  logic [KIND_W-1:0] st3_kind;
  logic [W-1:0]      st3_base, st3_half, st3_s2;
  logic [SUM_W-1:0]  st3_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      st3_vld <= 1'b0;
    end else if (en) begin
      st3_vld <= st2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st3_p1   <= P1_W'(st2_sum) * P1_W'(st2_da);
      st3_p2   <= P2_W'(st2_db) * P2_W'(st2_dc);
      st3_ab   <= SQ_W'(st2_s0) * SQ_W'(st2_s1);
      st3_kind <= kind_c;
      st3_base <= base_c;
      st3_half <= st2_s2 >> 1;
      st3_s2   <= st2_s2;
      st3_sum  <= st2_sum;
    end
  end

  // ---------------------------------------------------------------- stage 4: partial products
  localparam int PP_W = 2 * HALF;
  localparam int AP_W = 2 * W;

  logic              st4_vld;
  logic [PP_W-1:0]   st4_ll, st4_lh, st4_hl, st4_hh;
  logic [AP_W-1:0]   st4_abh, st4_abl;
  logic [KIND_W-1:0] st4_kind;
  logic [W-1:0]      st4_base, st4_half;
  logic [SUM_W-1:0]  st4_sum;

  logic [HALF-1:0] p1l, p1h, p2l, p2h;
  assign p1l = st3_p1[HALF-1:0];
  assign p1h = HALF'(st3_p1 >> HALF);
  assign p2l = st3_p2[HALF-1:0];
  assign p2h = HALF'(st3_p2 >> HALF);

  always_ff @(posedge clk) begin
    if (rst) begin
      st4_vld <= 1'b0;
    end else if (en) begin
      st4_vld <= st3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st4_ll   <= PP_W'(p1l) * PP_W'(p2l);
      st4_lh   <= PP_W'(p1l) * PP_W'(p2h);
      st4_hl   <= PP_W'(p1h) * PP_W'(p2l);
      st4_hh   <= PP_W'(p1h) * PP_W'(p2h);
      st4_abh  <= AP_W'(st3_ab[SQ_W-1:W]) * AP_W'(st3_s2);
      st4_abl  <= AP_W'(st3_ab[W-1:0]) * AP_W'(st3_s2);
      st4_kind <= st3_kind;
      st4_base <= st3_base;
      st4_half <= st3_half;
      st4_sum  <= st3_sum;
    end
  end

  // ---------------------------------------------------------------- stage 5: combine
  logic              st5_vld;
  logic [PROD_W-1:0] st5_prod;
  logic [ABC_W-1:0]  st5_abc;
  logic [KIND_W-1:0] st5_kind;
  logic [W-1:0]      st5_base, st5_half;
  logic [SUM_W-1:0]  st5_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      st5_vld <= 1'b0;
    end else if (en) begin
      st5_vld <= st4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st5_prod <= (PROD_W'(st4_hh) << (2 * HALF))
                + ((PROD_W'(st4_lh) + PROD_W'(st4_hl)) << HALF)
                + PROD_W'(st4_ll);
      st5_abc  <= (ABC_W'(st4_abh) << W) + ABC_W'(st4_abl);
      st5_kind <= st4_kind;
      st5_base <= st4_base;
      st5_half <= st4_half;
      st5_sum  <= st4_sum;
    end
  end

  // ---------------------------------------------------------------- Heron root
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [W-1:0]      base;
    logic [W-1:0]      half;
    logic [SUM_W-1:0]  sum;
    logic [ABC_W-1:0]  abc;
  } root_sb_t;

  root_sb_t        rs_in, rs_out;
  logic            rt_vld;
  logic [RW-1:0]   area_rt;

  assign rs_in = '{kind: st5_kind, base: st5_base, half: st5_half,
                   sum: st5_sum, abc: st5_abc};

  // area = isqrt(16 S^2 scaled, dropped by 2F+4 bits)
  tcm_isqrt #(
    .XW  (X_W),
    .SBW ($bits(root_sb_t))
  ) u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (st5_vld),
    .x       (st5_prod[PROD_W-1:2*F+4]),
    .in_sb   (rs_in),
    .out_vld (rt_vld),
    .root    (area_rt),
    .out_sb  (rs_out)
  );

  // ---------------------------------------------------------------- dividers
  logic [NR_W-1:0] twice_area;
  assign twice_area = NR_W'({area_rt, {(F+1){1'b0}}});

  logic              r_vld, h_vld, o_vld, r_sat, h_sat, o_sat;
  logic [QUO_W-1:0]  r_q, h_q, o_q;
  logic [KIND_W-1:0] r_kind;
  logic [W-1:0]      h_half;
  logic [RW-1:0]     o_area;

  // inner radius: 2 area / perimeter
  tcm_div #(
    .NW (NR_W), .DW (SUM_W), .QW (QUO_W), .SBW (KIND_W)
  ) u_div_inner (
    .clk (clk), .rst (rst), .en (en),
    .in_vld (rt_vld), .num (twice_area), .den (rs_out.sum), .in_sb (rs_out.kind),
    .out_vld (r_vld), .quo (r_q), .sat (r_sat), .out_sb (r_kind)
  );

  // altitude: 2 area / base
  tcm_div #(
    .NW (NR_W), .DW (W), .QW (QUO_W), .SBW (W)
  ) u_div_height (
    .clk (clk), .rst (rst), .en (en),
    .in_vld (rt_vld), .num (twice_area), .den (rs_out.base), .in_sb (rs_out.half),
    .out_vld (h_vld), .quo (h_q), .sat (h_sat), .out_sb (h_half)
  );

  // circumradius: abc / 4 area; zero area saturates through the overflow check
  tcm_div #(
    .NW (NO_W), .DW (DO_W), .QW (QUO_W), .SBW (RW)
  ) u_div_outer (
    .clk (clk), .rst (rst), .en (en),
    .in_vld (rt_vld), .num (NO_W'(rs_out.abc)),
    .den ({area_rt, {(F+2){1'b0}}}), .in_sb (area_rt),
    .out_vld (o_vld), .quo (o_q), .sat (o_sat), .out_sb (o_area)
  );

  // ---------------------------------------------------------------- output format
  logic [RAD_W-1:0]  r24, h24, h_equi;
  logic [RAD_W+1:0]  r3;
  logic [KIND_W-1:0] kind_n;
  logic [AREA_W-1:0] area_n;
  logic [RAD_W-1:0]  inner_n, height_n, median_n;
  logic [OUTR_W-1:0] outer_n;
  logic              clip_n;

  always_comb begin
    r24    = (r_sat || (|r_q[QUO_W-1:RAD_W])) ? '1 : r_q[RAD_W-1:0];
    h24    = (h_sat || (|h_q[QUO_W-1:RAD_W])) ? '1 : h_q[RAD_W-1:0];
    r3     = (RAD_W+2)'(r24) + (RAD_W+2)'({r24, 1'b0});
    h_equi = (|r3[RAD_W+1:RAD_W]) ? '1 : r3[RAD_W-1:0];

    kind_n   = r_kind;
    area_n   = AREA_W'(o_area);
    inner_n  = r24;
    outer_n  = OUTR_W'(o_q);
    clip_n   = o_sat;
    height_n = '0;
    median_n = '0;
    case (r_kind)
      KIND_DEGEN: begin
        area_n  = '0;
        inner_n = '0;
        outer_n = '0;
        clip_n  = 1'b0;
      end
      KIND_SCALENE: ;
      KIND_EQUI: begin
        height_n = h_equi;
        median_n = h_equi;
      end
      KIND_ISO: begin
        height_n = h24;
        median_n = h24;
      end
      KIND_ISO_RT, KIND_RIGHT: begin
        height_n = h24;
        median_n = RAD_W'(h_half);
      end
      default: begin
        kind_n  = KIND_DEGEN;
        area_n  = '0;
        inner_n = '0;
        outer_n = '0;
        clip_n  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= r_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.kind           <= kind_n;
      result.area           <= area_n;
      result.inner_radius   <= inner_n;
      result.outer_radius   <= outer_n;
      result.height         <= height_n;
      result.median         <= median_n;
      result.radius_clipped <= clip_n;
    end
  end

  // ---------------------------------------------------------------- checks
  // the three divider lanes must stay in lock step
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    (r_vld == h_vld) && (r_vld == o_vld))
    else $error("divider lanes out of step");

  // a clipped circumradius is always all ones
  a_clip_ones: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.radius_clipped) |-> (&result.outer_radius))
    else $error("clipped radius not saturated");

  // an item reaching the output came from an item that reached the dividers
  a_out_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(r_vld))
    else $error("result without divider item");

endmodule

// ===== rtl/core/tcm_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcm_isqrt: pipelined integer square root
// One root bit per stage, restoring digit recurrence, sideband rides along.
// ----------------------------------------------------------------------------
module tcm_isqrt #(
  parameter int XW  = 81,
  parameter int SBW = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic [XW-1:0]          x,
  input  logic [SBW-1:0]         in_sb,
  output logic                   out_vld,
  output logic [(XW+1)/2-1:0]    root,
  output logic [SBW-1:0]         out_sb
);
  import tcm_pkg::*;

  localparam int RW = (XW + 1) / 2;

  logic              vld [0:RW];
  logic [RW:0]       rem [0:RW];
  logic [RW-1:0]     rt  [0:RW];
  logic [2*RW-1:0]   xs  [0:RW];
  logic [SBW-1:0]    sb  [0:RW];

  assign vld[0] = in_vld;
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign xs[0]  = (2*RW)'(x);
  assign sb[0]  = in_sb;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+2:0] rem_sh;
    logic [RW+2:0] trial;
    logic          ge;

    assign rem_sh = {rem[k], xs[k][2*RW-1 -: 2]};
    assign trial  = (RW+3)'({rt[k], 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= (RW+1)'(ge ? rem_sh - trial : rem_sh);
        rt[k+1]  <= RW'({rt[k], ge});
        xs[k+1]  <= xs[k] << 2;
        sb[k+1]  <= sb[k];
      end
    end
  end

  assign out_vld = vld[RW];
  assign root    = rt[RW];
  assign out_sb  = sb[RW];

endmodule

// ===== rtl/core/tcm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcm_div: pipelined saturating restoring divider
// One quotient bit per stage after a registered overflow check.
// ----------------------------------------------------------------------------
module tcm_div #(
  parameter int NW  = 50,
  parameter int DW  = 26,
  parameter int QW  = 32,
  parameter int SBW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_vld,
  input  logic [NW-1:0]  num,
  input  logic [DW-1:0]  den,
  input  logic [SBW-1:0] in_sb,
  output logic           out_vld,
  output logic [QW-1:0]  quo,
  output logic           sat,
  output logic [SBW-1:0] out_sb
);
  import tcm_pkg::*;

  localparam int CW = maxi(NW, DW + QW);
  localparam int XW = NW + DW + 1;

  logic           vld [0:QW];
  logic [DW-1:0]  rem [0:QW];
  logic [QW-1:0]  nb  [0:QW];
  logic [QW-1:0]  q   [0:QW];
  logic [DW-1:0]  dv  [0:QW];
  logic           ov  [0:QW];
  logic [SBW-1:0] sb  [0:QW];

  logic [XW-1:0] ext;
  assign ext = XW'(num);

  // overflow check and first partial remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ov[0]  <= CW'(num) >= CW'({den, {QW{1'b0}}});
      rem[0] <= ext[QW +: DW];
      nb[0]  <= num[QW-1:0];
      q[0]   <= '0;
      dv[0]  <= den;
      sb[0]  <= in_sb;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0] sh;
    logic        ge;

    assign sh = {rem[k], nb[k][QW-1]};
    assign ge = sh >= {1'b0, dv[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= DW'(ge ? sh - {1'b0, dv[k]} : sh);
        nb[k+1]  <= nb[k] << 1;
        q[k+1]   <= QW'({q[k], ge});
        dv[k+1]  <= dv[k];
        ov[k+1]  <= ov[k];
        sb[k+1]  <= sb[k];
      end
    end
  end

  assign out_vld = vld[QW];
  assign sat     = ov[QW];
  assign quo     = ov[QW] ? '1 : q[QW];
  assign out_sb  = sb[QW];

endmodule
